FILE: hdl/ffa_pkg.sv
// ffa_pkg: shared constants, status codes and shared-adder types for the
// first-fit heap allocator. No dependencies; compiled first.
package ffa_pkg;

   // default heap size and fixed header granule
   localparam int unsigned HEAP_BYTES_DEF = 4096;
   localparam int unsigned ALIGN_BYTES    = 8;
   localparam int unsigned ALIGN_SHIFT    = 3;

   // item field widths
   localparam int unsigned SIZE_W   = 16;
   localparam int unsigned POFF_W   = 12;
   localparam int unsigned STATUS_W = 3;

   // granule count of a rounded request, and the bits of a payload offset above the granule
   localparam int unsigned NEED_W = SIZE_W + 1 - ALIGN_SHIFT;
   localparam int unsigned POFF_GRAN_W = POFF_W - ALIGN_SHIFT;

   // shared adder width: holds size + 7 and signed differences of granule counts
   localparam int unsigned ALU_W = 18;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_SIZE    = 3'd1,
      STATUS_TOO_LARGE   = 3'd2,
      STATUS_NO_FIT      = 3'd3,
      STATUS_BAD_POINTER = 3'd4,
      STATUS_DOUBLE_FREE = 3'd5
   } status_type;

   // shared adder operation: a + (b or ~b) + carry
   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             inv_b;
      logic             carry_in;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             neg;
      logic             zero;
   } alu_rsp_type;

endpackage

FILE: hdl/ffa_req_if.sv
// ffa_req_if: request channel of the heap allocator (valid/ready plus item fields).
// Depends on ffa_pkg for the field widths.
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [ffa_pkg::SIZE_W-1:0]  req_size;
   logic [ffa_pkg::POFF_W-1:0]  payload_offset;

   modport source (output valid, output op, output req_size, output payload_offset,
                   input ready);
   modport sink   (input valid, input op, input req_size, input payload_offset,
                   output ready);
endinterface

FILE: hdl/ffa_rsp_if.sv
// ffa_rsp_if: result channel of the heap allocator (valid/ready plus item fields).
// Depends on ffa_pkg for the field widths.
interface ffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffa_pkg::STATUS_W-1:0]  status;
   logic [ffa_pkg::POFF_W-1:0]    alloc_offset;

   modport source (output valid, output status, output alloc_offset, input ready);
   modport sink   (input valid, input status, input alloc_offset, output ready);
endinterface

FILE: hdl/ffa_ram.sv
// ffa_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module ffa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/ffa_alu.sv
// ffa_alu: shared adder/subtractor of the allocator sequencer, with sign and zero flags.
// Depends on ffa_pkg for the operation types.
module ffa_alu (
   input  ffa_pkg::alu_req_type alu_req,
   output ffa_pkg::alu_rsp_type alu_rsp
);

   logic [ffa_pkg::ALU_W-1:0] b_eff;
   logic [ffa_pkg::ALU_W-1:0] sum;

   // add, or subtract via inverted operand and carry
   always_comb begin
      b_eff = alu_req.inv_b ? ~alu_req.b : alu_req.b;
      sum   = alu_req.a + b_eff + ffa_pkg::ALU_W'(alu_req.carry_in);
      alu_rsp.sum  = sum;
      alu_rsp.neg  = sum[ffa_pkg::ALU_W-1];
      alu_rsp.zero = (sum == '0);
   end

endmodule

FILE: hdl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: first-fit allocator over a header RAM, one item at a time.
// Allocate: accept, size checks, a read, check and step per header passed over, then
// a split or a whole take and the result. Free: accept, pointer checks, a position check
// and step per header passed over, merges, then the result. Every chunk spans two granules
// or more. Reset: synchronous; after reset S_INIT writes the free header at slot 0,
// then the request channel becomes ready. Depends on ffa_pkg, ffa_alu, ffa_ram, interfaces.
module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
   input logic    clock,
   input logic    reset,
   ffa_req_if.sink   req_chan,
   ffa_rsp_if.source rsp_chan
);

   localparam int unsigned SLOTS  = HEAP_BYTES / ffa_pkg::ALIGN_BYTES;
   localparam int unsigned SLOT_W = $clog2(SLOTS);
   localparam int unsigned OFF_W  = $clog2(SLOTS + 1);
   localparam int unsigned HDR_W  = SLOT_W + 1;
   localparam int unsigned AW     = ffa_pkg::ALU_W;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_A_SIZE, S_A_NEED, S_A_ROOM, S_A_RD, S_A_CHK, S_A_NEXT,
      S_A_SPL, S_A_SPL2, S_A_DONE,
      S_F_TGT, S_F_POS, S_F_WCHK, S_F_TCHK, S_F_NRD, S_F_NCHK, S_F_PREV, S_F_CLR,
      S_FIN
   } state_type;

   state_type                      state_ff, state_in;
   logic [ffa_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [ffa_pkg::POFF_W-1:0]     poff_ff, poff_in;
   logic [ffa_pkg::NEED_W-1:0]     need_ff, need_in;
   logic [OFF_W-1:0]               off_ff, off_in;
   logic [OFF_W-1:0]               next_ff, next_in;
   logic [SLOT_W-1:0]              tgt_ff, tgt_in;
   logic [SLOT_W-1:0]              len_ff, len_in;
   logic [SLOT_W-1:0]              rem_ff, rem_in;
   logic [SLOT_W-1:0]              prev_ff, prev_in;
   logic [SLOT_W-1:0]              prev_len_ff, prev_len_in;
   logic                           prev_free_ff, prev_free_in;
   logic                           have_prev_ff, have_prev_in;
   ffa_pkg::status_type            res_status_ff, res_status_in;
   logic [ffa_pkg::POFF_W-1:0]     res_offset_ff, res_offset_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ffa_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [ffa_pkg::POFF_W-1:0]     rsp_offset_ff, rsp_offset_in;

   ffa_pkg::alu_req_type           alu_req;
   ffa_pkg::alu_rsp_type           alu_rsp;

   logic                           wr_en;
   logic [SLOT_W-1:0]              wr_addr;
   logic [HDR_W-1:0]               wr_data;
   logic [SLOT_W-1:0]              rd_addr;
   logic [HDR_W-1:0]               rd_data;
   logic                           hdr_free;
   logic [SLOT_W-1:0]              hdr_len;

   // shared adder
   ffa_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // chunk header store: free flag over length in granules
   ffa_ram #(
      .WIDTH (HDR_W),
      .DEPTH (SLOTS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hdr_free = rd_data[SLOT_W];
   assign hdr_len  = rd_data[SLOT_W-1:0];
   assign rd_addr  = (state_ff == S_F_NRD) ? next_ff[SLOT_W-1:0] : off_ff[SLOT_W-1:0];

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.alloc_offset = rsp_offset_ff;

   // sequencer: walk control, adder operands and header writes
   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      poff_in       = poff_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      next_in       = next_ff;
      tgt_in        = tgt_ff;
      len_in        = len_ff;
      rem_in        = rem_ff;
      prev_in       = prev_ff;
      prev_len_in   = prev_len_ff;
      prev_free_in  = prev_free_ff;
      have_prev_in  = have_prev_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      alu_req       = '0;
      wr_en         = 1'b0;
      wr_addr       = off_ff[SLOT_W-1:0];
      wr_data       = '0;
      req_chan.ready = 1'b0;

      // result item taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // whole heap as one free chunk
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {1'b1, SLOT_W'(SLOTS - 1)};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               size_in       = req_chan.req_size;
               poff_in       = req_chan.payload_offset;
               res_offset_in = '0;
               state_in      = (req_chan.op == ffa_pkg::OP_FREE) ? S_F_TGT : S_A_SIZE;
            end
         end
         S_A_SIZE: begin
            // size - heap - 1 negative means size fits the heap
            alu_req.a     = AW'(size_ff);
            alu_req.b     = AW'(HEAP_BYTES);
            alu_req.inv_b = 1'b1;
            if (size_ff == '0 || !alu_rsp.neg) begin
               res_status_in = ffa_pkg::STATUS_BAD_SIZE;
               state_in      = S_FIN;
            end else begin
               state_in = S_A_NEED;
            end
         end
         S_A_NEED: begin
            // round up to whole granules
            alu_req.a = AW'(size_ff);
            alu_req.b = AW'(ffa_pkg::ALIGN_BYTES - 1);
            need_in   = alu_rsp.sum[ffa_pkg::ALIGN_SHIFT +: ffa_pkg::NEED_W];
            state_in  = S_A_ROOM;
         end
         S_A_ROOM: begin
            // room for the request plus its header
            alu_req.a        = AW'(need_ff);
            alu_req.b        = AW'(SLOTS);
            alu_req.inv_b    = 1'b1;
            alu_req.carry_in = 1'b1;
            if (!alu_rsp.neg) begin
               res_status_in = ffa_pkg::STATUS_TOO_LARGE;
               state_in      = S_FIN;
            end else begin
               off_in   = '0;
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            // remainder = len - need - 1
            alu_req.a     = AW'(hdr_len);
            alu_req.b     = AW'(need_ff);
            alu_req.inv_b = 1'b1;
            len_in        = hdr_len;
            rem_in        = alu_rsp.sum[SLOT_W-1:0];
            if (!hdr_free || (alu_rsp.neg && !(&alu_rsp.sum))) begin
               state_in = S_A_NEXT;
            end else if (!alu_rsp.neg && (|alu_rsp.sum[AW-1:1])) begin
               state_in = S_A_SPL;
            end else begin
               // thin remainder: take the chunk whole
               wr_en    = 1'b1;
               wr_data  = {1'b0, hdr_len};
               state_in = S_A_DONE;
            end
         end
         S_A_NEXT: begin
            alu_req.a        = AW'(off_ff);
            alu_req.b        = AW'(len_ff);
            alu_req.carry_in = 1'b1;
            off_in           = alu_rsp.sum[OFF_W-1:0];
            if (alu_rsp.sum >= AW'(SLOTS)) begin
               res_status_in = ffa_pkg::STATUS_NO_FIT;
               state_in      = S_FIN;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_SPL: begin
            // free rest after the new chunk
            alu_req.a        = AW'(off_ff);
            alu_req.b        = AW'(need_ff);
            alu_req.carry_in = 1'b1;
            wr_en            = 1'b1;
            wr_addr          = alu_rsp.sum[SLOT_W-1:0];
            wr_data          = {1'b1, rem_ff};
            state_in         = S_A_SPL2;
         end
         S_A_SPL2: begin
            wr_en    = 1'b1;
            wr_data  = {1'b0, need_ff[SLOT_W-1:0]};
            state_in = S_A_DONE;
         end
         S_A_DONE: begin
            // payload sits one granule after the header
            alu_req.a        = AW'(off_ff);
            alu_req.carry_in = 1'b1;
            res_offset_in    = {alu_rsp.sum[ffa_pkg::POFF_GRAN_W-1:0],
                                ffa_pkg::ALIGN_SHIFT'(0)};
            res_status_in    = ffa_pkg::STATUS_OK;
            state_in         = S_FIN;
         end
         S_F_TGT: begin
            // header granule = payload granule - 1
            alu_req.a     = AW'(poff_ff[ffa_pkg::POFF_W-1:ffa_pkg::ALIGN_SHIFT]);
            alu_req.inv_b = 1'b1;
            tgt_in        = alu_rsp.sum[SLOT_W-1:0];
            off_in        = '0;
            have_prev_in  = 1'b0;
            if (poff_ff[ffa_pkg::ALIGN_SHIFT-1:0] != '0
                  || poff_ff[ffa_pkg::POFF_W-1:ffa_pkg::ALIGN_SHIFT] == '0
                  || alu_rsp.sum >= AW'(SLOTS)) begin
               res_status_in = ffa_pkg::STATUS_BAD_POINTER;
               state_in      = S_FIN;
            end else begin
               state_in = S_F_POS;
            end
         end
         S_F_POS: begin
            // compare walk position to the target; header at off is read meanwhile
            alu_req.a        = AW'(off_ff);
            alu_req.b        = AW'(tgt_ff);
            alu_req.inv_b    = 1'b1;
            alu_req.carry_in = 1'b1;
            if (off_ff >= OFF_W'(SLOTS) || (!alu_rsp.neg && !alu_rsp.zero)) begin
               res_status_in = ffa_pkg::STATUS_BAD_POINTER;
               state_in      = S_FIN;
            end else if (alu_rsp.zero) begin
               state_in = S_F_TCHK;
            end else begin
               state_in = S_F_WCHK;
            end
         end
         S_F_WCHK: begin
            // remember this chunk as the left neighbour, step on
            prev_in          = off_ff[SLOT_W-1:0];
            prev_free_in     = hdr_free;
            prev_len_in      = hdr_len;
            have_prev_in     = 1'b1;
            alu_req.a        = AW'(off_ff);
            alu_req.b        = AW'(hdr_len);
            alu_req.carry_in = 1'b1;
            off_in           = alu_rsp.sum[OFF_W-1:0];
            state_in         = S_F_POS;
         end
         S_F_TCHK: begin
            alu_req.a        = AW'(off_ff);
            alu_req.b        = AW'(hdr_len);
            alu_req.carry_in = 1'b1;
            len_in           = hdr_len;
            next_in          = alu_rsp.sum[OFF_W-1:0];
            if (hdr_free) begin
               res_status_in = ffa_pkg::STATUS_DOUBLE_FREE;
               state_in      = S_FIN;
            end else if (alu_rsp.sum >= AW'(SLOTS)) begin
               state_in = S_F_PREV;
            end else begin
               state_in = S_F_NRD;
            end
         end
         S_F_NRD: begin
            state_in = S_F_NCHK;
         end
         S_F_NCHK: begin
            // absorb a free right neighbour
            alu_req.a        = AW'(len_ff);
            alu_req.b        = AW'(hdr_len);
            alu_req.carry_in = 1'b1;
            if (hdr_free) begin
               len_in  = alu_rsp.sum[SLOT_W-1:0];
               wr_en   = 1'b1;
               wr_addr = next_ff[SLOT_W-1:0];
               wr_data = '0;
            end
            state_in = S_F_PREV;
         end
         S_F_PREV: begin
            alu_req.a        = AW'(prev_len_ff);
            alu_req.b        = AW'(len_ff);
            alu_req.carry_in = 1'b1;
            wr_en            = 1'b1;
            if (have_prev_ff && prev_free_ff) begin
               // fold into the free left neighbour
               wr_addr  = prev_ff;
               wr_data  = {1'b1, alu_rsp.sum[SLOT_W-1:0]};
               state_in = S_F_CLR;
            end else begin
               wr_data       = {1'b1, len_ff};
               res_status_in = ffa_pkg::STATUS_OK;
               state_in      = S_FIN;
            end
         end
         S_F_CLR: begin
            wr_en         = 1'b1;
            wr_data       = '0;
            res_status_in = ffa_pkg::STATUS_OK;
            state_in      = S_FIN;
         end
         S_FIN: begin
            // hand the result item to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
      end
      size_ff       <= size_in;
      poff_ff       <= poff_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      next_ff       <= next_in;
      tgt_ff        <= tgt_in;
      len_ff        <= len_in;
      rem_ff        <= rem_in;
      prev_ff       <= prev_in;
      prev_len_ff   <= prev_len_in;
      prev_free_ff  <= prev_free_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // an accepted item always starts a walk
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff != S_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // failed requests never report an offset
   a_err_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ffa_pkg::STATUS_OK |-> rsp_offset_ff == '0)
      else $error("non-zero offset on an error result");

   // allocate walk only reads inside the heap
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_A_RD |-> off_ff < OFF_W'(SLOTS))
      else $error("allocate walk beyond heap end");

   // left neighbour lies strictly behind the walk position
   a_prev_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_F_POS && have_prev_ff |-> OFF_W'(prev_ff) < off_ff)
      else $error("left neighbour not behind walk position");

   // header writes only while working on an item or at start-up
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != S_IDLE && state_ff != S_FIN)
      else $error("header write outside an item");

endmodule
